// ===== rtl/core/gfgh_pkg.sv =====
// Package for the Gaussian fit gradient and Hessian accumulator.
// Holds shared types, term widths, queue sizing and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gfgh_pkg;

    // Input queue between the front and the back of the block.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Width of the per-sample terms after the fixed-point shifts.
    localparam int GRAD_TERM_W = 33;
    localparam int HESS_TERM_W = 41;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SIGMA_XY_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SIGMA_Z_SQ  = 2'd1;
    localparam logic [CFG_DATA_W-1:0] INV_SIGMA_RESET    = 16'h8000;

    // One sample as it sits in the input queue.
    typedef struct packed {
        logic signed [15:0] x_offset;
        logic signed [15:0] y_offset;
        logic signed [15:0] z_offset;
        logic signed [15:0] model_term;
        logic signed [15:0] data_term;
        logic               last_sample;
    } t_sample;

    // Control that travels with an item down the back pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // Terms to add to the sums for one sample.
    // Hessian order: xx, xy, xz, yy, yz, zz.
    typedef struct packed {
        logic [2:0][GRAD_TERM_W-1:0] grad;
        logic [5:0][HESS_TERM_W-1:0] hess;
    } t_terms;

endpackage

`default_nettype wire

// ===== rtl/core/gfgh_ifs.sv =====
// Channel interfaces for the Gaussian fit accumulator: sample input and result output.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gfgh_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
    logic signed [15:0] z_offset;
    logic signed [15:0] model_term;
    logic signed [15:0] data_term;
    logic               last_sample;

    modport source (
        output valid, x_offset, y_offset, z_offset, model_term, data_term, last_sample,
        input  ready
    );
    modport sink (
        input  valid, x_offset, y_offset, z_offset, model_term, data_term, last_sample,
        output ready
    );
endinterface

interface gfgh_out_if #(
    parameter int ACC_WIDTH = 48
);
    logic                        valid;
    logic                        ready;
    logic signed [ACC_WIDTH-1:0] grad_x;
    logic signed [ACC_WIDTH-1:0] grad_y;
    logic signed [ACC_WIDTH-1:0] grad_z;
    logic signed [ACC_WIDTH-1:0] hess_xx;
    logic signed [ACC_WIDTH-1:0] hess_xy;
    logic signed [ACC_WIDTH-1:0] hess_xz;
    logic signed [ACC_WIDTH-1:0] hess_yy;
    logic signed [ACC_WIDTH-1:0] hess_yz;
    logic signed [ACC_WIDTH-1:0] hess_zz;
    logic                        saturated;

    modport source (
        output valid, grad_x, grad_y, grad_z, hess_xx, hess_xy, hess_xz,
               hess_yy, hess_yz, hess_zz, saturated,
        input  ready
    );
    modport sink (
        input  valid, grad_x, grad_y, grad_z, hess_xx, hess_xy, hess_xz,
               hess_yy, hess_yz, hess_zz, saturated,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/gfgh_front.sv =====
// Front end: accepts sample transactions into a short queue and presents the head.
// Depends on gfgh_pkg and gfgh_in_if.
`timescale 1ns / 1ps
`default_nettype none

module gfgh_front
    import gfgh_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gfgh_in_if.sink      i_smp,
    input  wire logic    i_pop,
    output logic         o_vld,
    output t_sample      o_item
);

    t_sample               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_AW:0]     r_cnt;
    logic                  push;
    logic                  pop;

    // Accept while the queue has room.
    assign i_smp.ready = (r_cnt != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign push        = i_smp.valid && i_smp.ready;
    assign o_vld       = (r_cnt != '0);
    assign pop         = i_pop && o_vld;
    assign o_item      = r_mem[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{x_offset:    i_smp.x_offset,
                             y_offset:    i_smp.y_offset,
                             z_offset:    i_smp.z_offset,
                             model_term:  i_smp.model_term,
                             data_term:   i_smp.data_term,
                             last_sample: i_smp.last_sample};
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gfgh_prod.sv =====
// Back end product pipeline: three stages from a sample to its gradient and Hessian terms.
// Depends on gfgh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfgh_prod
    import gfgh_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire logic                  i_vld,
    input  wire t_sample               i_item,
    input  wire logic [CFG_DATA_W-1:0] i_inv_xy,
    input  wire logic [CFG_DATA_W-1:0] i_inv_z,
    output t_ctl                       o_ctl,
    output t_terms                     o_terms
);

    // Stage 1: h*g, h*(h-g) and the coordinate products.
    t_ctl               r1_ctl;
    logic signed [31:0] r1_hg;
    logic signed [32:0] r1_hd;
    logic signed [31:0] r1_ab [6];
    logic signed [15:0] r1_c  [3];
    logic signed [16:0] n1_d;

    // Stage 2: gradient, Hessian and sigma products.
    t_ctl               r2_ctl;
    logic signed [47:0] r2_gc [3];
    logic signed [64:0] r2_pq [6];
    logic signed [48:0] r2_sxy;
    logic signed [48:0] r2_sz;

    // Stage 3: floored terms.
    t_ctl               r3_ctl;
    t_terms             r3_terms;
    t_terms             n3_terms;
    logic signed [47:0] n3_g  [3];
    logic signed [65:0] n3_h  [6];

    assign n1_d = 17'(i_item.model_term) - 17'(i_item.data_term);

    // Pipeline control; the whole back end moves together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else if (i_adv) begin
            r1_ctl <= '{valid: i_vld, last: i_item.last_sample};
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    // Stage 1 data.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_hg    <= 32'(i_item.model_term) * 32'(i_item.data_term);
            r1_hd    <= 33'(i_item.model_term) * 33'(n1_d);
            r1_ab[0] <= 32'(i_item.x_offset) * 32'(i_item.x_offset);
            r1_ab[1] <= 32'(i_item.x_offset) * 32'(i_item.y_offset);
            r1_ab[2] <= 32'(i_item.x_offset) * 32'(i_item.z_offset);
            r1_ab[3] <= 32'(i_item.y_offset) * 32'(i_item.y_offset);
            r1_ab[4] <= 32'(i_item.y_offset) * 32'(i_item.z_offset);
            r1_ab[5] <= 32'(i_item.z_offset) * 32'(i_item.z_offset);
            r1_c[0]  <= i_item.x_offset;
            r1_c[1]  <= i_item.y_offset;
            r1_c[2]  <= i_item.z_offset;
        end
    end

    // Stage 2 data.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_gc[i] <= 48'(r1_hg) * 48'(r1_c[i]);
            end
            for (int k = 0; k < 6; k++) begin
                r2_pq[k] <= 65'(r1_hd) * 65'(r1_ab[k]);
            end
            r2_sxy <= 49'(r1_hg) * 49'($signed({1'b0, i_inv_xy}));
            r2_sz  <= 49'(r1_hg) * 49'($signed({1'b0, i_inv_z}));
        end
    end

    // Stage 3: gradient term is floor(-2hgc / 2^16); Hessian terms are
    // floor((2*p*q + 4*hg*inv) / 2^24), with the sigma part on the diagonal only.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_g[i] = (-r2_gc[i]) >>> 15;
        end
        for (int k = 0; k < 6; k++) begin
            n3_h[k] = 66'(r2_pq[k]) <<< 1;
        end
        n3_h[0] = n3_h[0] + (66'(r2_sxy) <<< 2);
        n3_h[3] = n3_h[3] + (66'(r2_sxy) <<< 2);
        n3_h[5] = n3_h[5] + (66'(r2_sz) <<< 2);
        n3_terms = '0;
        for (int i = 0; i < 3; i++) begin
            n3_terms.grad[i] = n3_g[i][GRAD_TERM_W-1:0];
        end
        for (int k = 0; k < 6; k++) begin
            n3_terms.hess[k] = n3_h[k][24 +: HESS_TERM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_terms <= n3_terms;
        end
    end

    assign o_ctl   = r3_ctl;
    assign o_terms = r3_terms;

endmodule

`default_nettype wire

// ===== rtl/core/gfgh_accum.sv =====
// Back end accumulator: saturating sums, clip flag and the result output register.
// Depends on gfgh_pkg and gfgh_out_if.
`timescale 1ns / 1ps
`default_nettype none

module gfgh_accum
    import gfgh_pkg::*;
#(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_ctl   i_ctl,
    input  wire t_terms i_terms,
    output logic        o_adv,
    gfgh_out_if.source  o_res
);

    localparam int SUM_W = ((ACC_WIDTH > HESS_TERM_W) ? ACC_WIDTH : HESS_TERM_W) + 1;
    localparam int TOP_W = SUM_W - ACC_WIDTH + 1;

    logic signed [ACC_WIDTH-1:0] r_sum  [9];
    logic signed [ACC_WIDTH-1:0] n_sum  [9];
    logic signed [ACC_WIDTH-1:0] r_out  [9];
    logic [8:0]                  n_clip;
    logic                        r_clip;
    logic                        r_out_sat;
    logic                        r_ovalid;
    logic                        take;

    // Add with clipping; bit ACC_WIDTH of the result flags a clip.
    function automatic logic [ACC_WIDTH:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [SUM_W-2:0]     term
    );
        logic signed [SUM_W-1:0] s;
        logic [TOP_W-1:0]        top;
        logic [ACC_WIDTH:0]      res;
        s   = $signed({{(SUM_W - ACC_WIDTH){acc[ACC_WIDTH-1]}}, acc})
            + $signed({term[SUM_W-2], term});
        top = s[SUM_W-1:ACC_WIDTH-1];
        if ((&top) || !(|top)) begin
            res = {1'b0, s[ACC_WIDTH-1:0]};
        end else if (s[SUM_W-1]) begin
            res = {1'b1, 1'b1, {(ACC_WIDTH - 1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(ACC_WIDTH - 1){1'b1}}};
        end
        return res;
    endfunction

    // The back end stalls only when a result is due and the output slot is still full.
    assign o_adv = !(i_ctl.valid && i_ctl.last && r_ovalid && !o_res.ready);
    assign take  = i_ctl.valid && o_adv;

    // Next sums for the item at the head of the back end.
    always_comb begin
        logic [ACC_WIDTH:0] r;
        for (int i = 0; i < 3; i++) begin
            r = sat_add(r_sum[i], (SUM_W - 1)'($signed(i_terms.grad[i])));
            n_sum[i]  = $signed(r[ACC_WIDTH-1:0]);
            n_clip[i] = r[ACC_WIDTH];
        end
        for (int k = 0; k < 6; k++) begin
            r = sat_add(r_sum[3 + k], (SUM_W - 1)'($signed(i_terms.hess[k])));
            n_sum[3 + k]  = $signed(r[ACC_WIDTH-1:0]);
            n_clip[3 + k] = r[ACC_WIDTH];
        end
    end

    // Sums and clip flag; a last sample hands them to the output and clears them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_sum[i] <= '0;
            end
            r_clip <= 1'b0;
        end else if (take) begin
            if (i_ctl.last) begin
                for (int i = 0; i < 9; i++) begin
                    r_sum[i] <= '0;
                end
                r_clip <= 1'b0;
            end else begin
                for (int i = 0; i < 9; i++) begin
                    r_sum[i] <= n_sum[i];
                end
                r_clip <= r_clip || (|n_clip);
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (take && i_ctl.last) begin
            for (int i = 0; i < 9; i++) begin
                r_out[i] <= n_sum[i];
            end
            r_out_sat <= r_clip || (|n_clip);
        end
    end

    // Output valid: set by a finished set, cleared when the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take && i_ctl.last) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.grad_x    = r_out[0];
    assign o_res.grad_y    = r_out[1];
    assign o_res.grad_z    = r_out[2];
    assign o_res.hess_xx   = r_out[3];
    assign o_res.hess_xy   = r_out[4];
    assign o_res.hess_xz   = r_out[5];
    assign o_res.hess_yy   = r_out[6];
    assign o_res.hess_yz   = r_out[7];
    assign o_res.hess_zz   = r_out[8];
    assign o_res.saturated = r_out_sat;

endmodule

`default_nettype wire

// ===== rtl/core/gaussian_fit_gradient_hessian_acc_top.sv =====
// Top level of the Gaussian fit gradient and Hessian accumulator.
// Depends on gfgh_pkg, gfgh_ifs, gfgh_front, gfgh_prod and gfgh_accum.
//
// Usage:
//   i_smp carries one sample per transaction: x, y, z offsets (Q8.8), model term h
//   and measured term g (Q4.12) and a last_sample mark. o_res carries one result
//   per set: gradient, the six unique Hessian entries (ACC_WIDTH bits, 16 fraction
//   bits) and a saturated flag. i_cfg_we/i_cfg_idx/i_cfg_wdata write the two
//   Q1.15 reciprocal sigma registers (index 0 lateral, index 1 axial).
// Timing:
//   One sample per cycle is sustained while the back end is not held (see Stalls).
//   The last sample of a set passes the four-entry input queue, three product
//   stages (16x16, then about 32x32 multiplies, then shift and add) and the
//   accumulate step, which loads the output register and makes the result valid.
// Reset:
//   Clears the sums, the clip flag, the queue and the output valid, and sets both
//   reciprocal registers to 1.0.
// Stalls:
//   While a result waits on o_res, samples keep flowing until the next last sample
//   reaches the accumulators; the back end then holds and the queue fills, after
//   which i_smp.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_fit_gradient_hessian_acc_top
    import gfgh_pkg::*;
#(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    gfgh_in_if.sink                    i_smp,
    gfgh_out_if.source                 o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [CFG_DATA_W-1:0] r_inv_xy;
    logic [CFG_DATA_W-1:0] r_inv_z;
    logic                  q_vld;
    t_sample               q_item;
    logic                  adv;
    t_ctl                  ctl;
    t_terms                terms;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_xy <= INV_SIGMA_RESET;
            r_inv_z  <= INV_SIGMA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV_SIGMA_XY_SQ: r_inv_xy <= i_cfg_wdata;
                CFG_INV_SIGMA_Z_SQ:  r_inv_z  <= i_cfg_wdata;
                default:             ;
            endcase
        end
    end

    gfgh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_smp),
        .i_pop   (adv),
        .o_vld   (q_vld),
        .o_item  (q_item)
    );

    gfgh_prod u_prod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_vld    (q_vld),
        .i_item   (q_item),
        .i_inv_xy (r_inv_xy),
        .i_inv_z  (r_inv_z),
        .o_ctl    (ctl),
        .o_terms  (terms)
    );

    gfgh_accum #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_terms (terms),
        .o_adv   (adv),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gfgh_checker.sv =====
// Port-level checks for the Gaussian fit accumulator, bound to its top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module gfgh_checker #(
    parameter int ACC_WIDTH = 48
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_in_last,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [ACC_WIDTH-1:0] i_out_grad_x,
    input wire logic                 i_out_sat
);

    logic [7:0] r_pending;

    // Sets whose last sample was accepted but whose result is not yet taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({i_in_valid && i_in_ready && i_in_last, i_out_valid && i_out_ready})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    // A result is only offered for a set that has been closed.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 8'd0))
        else $error("result offered with no closed set outstanding");

    // Reset empties the output.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload; grad_x and the saturated flag are checked.
    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_grad_x) && $stable(i_out_sat)))
        else $error("result payload changed while stalled");

endmodule

bind gaussian_fit_gradient_hessian_acc_top gfgh_checker #(
    .ACC_WIDTH (ACC_WIDTH)
) u_gfgh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_in_last    (i_smp.last_sample),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_grad_x (o_res.grad_x),
    .i_out_sat    (o_res.saturated)
);

`default_nettype wire
